[sv/flc_pkg.sv]
// Package for the full linear convolution core: field widths, function codes
// and the control bundle that the top level hands to each tap cell.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package flc_pkg;

	localparam int SAMPLE_W      = 16;
	localparam int ACC_W         = 32;
	localparam int MAX_TAPS_DEF  = 32;

	localparam logic FUNC_KERNEL = 1'b0;
	localparam logic FUNC_SIGNAL = 1'b1;

	// per-cell control, driven by the top level every cycle
	typedef struct packed {
		logic step;    // advance the partial-sum chain by one beat
		logic clr;     // zero the partial sum (new sequence)
		logic coef_we; // load this cell's kernel coefficient
		logic tap_en;  // cell lies inside the current kernel length
	} cell_ctrl_t;

endpackage

`default_nettype wire

[sv/flc_if.sv]
// Valid/ready channel interfaces for the convolution core: the input beat
// (function code, sample, last) and the result beat. Depends on flc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface flc_in_if import flc_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic                       func;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last;

	modport source (output valid, func, sample, last, input ready);
	modport sink   (input valid, func, sample, last, output ready);
endinterface

interface flc_out_if import flc_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic signed [ACC_W-1:0] conv_value;
	logic                    run_end;
	logic                    final_output;

	modport source (output valid, conv_value, run_end, final_output, input ready);
	modport sink   (input valid, conv_value, run_end, final_output, output ready);
endinterface

`default_nettype wire

[sv/flc_cell.sv]
// One tap cell of the transposed convolution chain: holds a kernel
// coefficient and a partial sum fed from its right-hand neighbor. Uses flc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module flc_cell import flc_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire cell_ctrl_t                 ctrl,
	input  wire logic signed [SAMPLE_W-1:0] x,
	input  wire logic signed [ACC_W-1:0]    psum_in,
	output logic signed [ACC_W-1:0]         psum
);

	logic signed [SAMPLE_W-1:0] coef_q;
	logic signed [ACC_W-1:0]    prod;
	logic signed [ACC_W-1:0]    sum;
	logic signed [ACC_W-1:0]    psum_q;

	always_ff @(posedge clk) begin
		if (ctrl.coef_we) begin
			coef_q <= x;
		end
	end

	assign prod = ACC_W'(x) * ACC_W'(coef_q);
	// cells past the kernel length pass the neighbor's sum unchanged
	assign sum  = (ctrl.tap_en ? prod : '0) + psum_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psum_q <= '0;
		end else if (ctrl.clr) begin
			psum_q <= '0;
		end else if (ctrl.step) begin
			psum_q <= sum;
		end
	end

	assign psum = psum_q;

endmodule

`default_nettype wire

[sv/full_linear_convolution_i16_core.sv]
// Full linear convolution core, signed 16-bit inputs, wrapping 32-bit sums.
// Input channel in_ch: func selects kernel element load or signal sample;
// last ends the kernel or the signal. A kernel load after a complete kernel
// starts a new kernel; loads beyond MAX_TAPS are dropped. Signal samples
// before the kernel is complete are taken and dropped.
// Output channel out_ch: one result per signal sample, plus kernel_length-1
// tail results after the last sample; run_end marks the last result of an
// input beat, final_output the last result of the sequence.
// A result is registered and appears in the cycle after its sample is taken.
// Throughput: one sample per cycle while out_ch is free and no tail flush runs,
// set by the row of tap cells (one multiply-add each) that all advance
// together. During the tail flush, in_ch.ready is low.
// Stall: while a result waits on out_ch, the chain holds and in_ch.ready
// stays low unless that result is taken in the same cycle.
// Reset clears the partial sums, the kernel length and the complete flag;
// kernel coefficients are undefined until loaded.
// Depends on flc_pkg, flc_if and flc_cell.
`timescale 1ns / 1ps
`default_nettype none

module full_linear_convolution_i16_core import flc_pkg::*; #(
	parameter int MAX_TAPS = MAX_TAPS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	flc_in_if.sink     in_ch,
	flc_out_if.source  out_ch
);

	localparam int LW = $clog2(MAX_TAPS + 1);

	logic [LW-1:0]              kernel_len_q;
	logic                       kernel_complete_q;
	logic                       flush_q;
	logic [LW-1:0]              flush_cnt_q;
	logic                       out_valid_q;
	logic                       run_end_q;
	logic                       final_q;

	logic                       out_free;
	logic                       in_take;
	logic                       load_take;
	logic                       sig_take;
	logic                       flush_step;
	logic                       step;
	logic                       end_seq;
	logic                       new_kernel;
	logic [LW-1:0]              wr_idx;
	logic                       wr_ok;
	logic signed [SAMPLE_W-1:0] x;
	logic                       step_run_end;

	cell_ctrl_t                 ctrl [MAX_TAPS];
	logic signed [ACC_W-1:0]    psum [MAX_TAPS];

	assign out_free   = !out_valid_q || out_ch.ready;
	assign in_ch.ready = !flush_q && out_free;
	assign in_take    = in_ch.valid && in_ch.ready;
	assign load_take  = in_take && (in_ch.func == FUNC_KERNEL);
	assign sig_take   = in_take && (in_ch.func == FUNC_SIGNAL) && kernel_complete_q;
	assign flush_step = flush_q && out_free;
	assign step       = sig_take || flush_step;

	// last beat of a sequence: the last sample of a one-tap kernel, or the
	// final tail beat of the flush
	assign end_seq = (sig_take && in_ch.last && (kernel_len_q <= LW'(1))) ||
	                 (flush_step && (flush_cnt_q == LW'(1)));
	assign step_run_end = end_seq || (sig_take && !in_ch.last);

	assign new_kernel = load_take && kernel_complete_q;
	assign wr_idx     = kernel_complete_q ? '0 : kernel_len_q;
	assign wr_ok      = kernel_complete_q || (kernel_len_q < LW'(MAX_TAPS));

	// shift zeros in during the tail flush
	assign x = flush_q ? '0 : in_ch.sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_len_q      <= '0;
			kernel_complete_q <= 1'b0;
		end else if (load_take) begin
			kernel_complete_q <= in_ch.last;
			if (wr_ok) begin
				kernel_len_q <= wr_idx + LW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_q     <= 1'b0;
			flush_cnt_q <= '0;
		end else if (sig_take && in_ch.last && (kernel_len_q > LW'(1))) begin
			flush_q     <= 1'b1;
			flush_cnt_q <= kernel_len_q - LW'(1);
		end else if (flush_step) begin
			flush_cnt_q <= flush_cnt_q - LW'(1);
			if (flush_cnt_q == LW'(1)) begin
				flush_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			run_end_q   <= 1'b0;
			final_q     <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
			run_end_q   <= step_run_end;
			final_q     <= end_seq;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	for (genvar k = 0; k < MAX_TAPS; k++) begin : g_tap
		always_comb begin
			ctrl[k].step    = step;
			// cell 0 holds the result beat, so it is never cleared
			ctrl[k].clr     = (k != 0) && (end_seq || new_kernel);
			ctrl[k].coef_we = load_take && wr_ok && (wr_idx == LW'(k));
			ctrl[k].tap_en  = LW'(k) < kernel_len_q;
		end

		if (k == MAX_TAPS - 1) begin : g_end
			flc_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctrl    (ctrl[k]),
				.x       (x),
				.psum_in ('0),
				.psum    (psum[k])
			);
		end else begin : g_mid
			flc_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctrl    (ctrl[k]),
				.x       (x),
				.psum_in (psum[k+1]),
				.psum    (psum[k])
			);
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.conv_value   = psum[0];
	assign out_ch.run_end      = run_end_q;
	assign out_ch.final_output = final_q;

`ifndef SYNTHESIS
	a_flush_needs_kernel: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> kernel_complete_q)
		else $error("tail flush without a complete kernel");

	a_flush_count: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> (flush_cnt_q != '0) && (flush_cnt_q < kernel_len_q))
		else $error("tail flush count out of range");

	a_final_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && final_q) |-> run_end_q)
		else $error("final result not marked as end of run");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kernel_len_q <= LW'(MAX_TAPS))
		else $error("kernel length beyond tap count");
`endif

endmodule

`default_nettype wire

[verif/full_linear_convolution_i16_core_tb.sv]
// Self-checking testbench for full_linear_convolution_i16_core: a directed and a random
// run of kernel loads and signal sequences, with the expected outputs predicted beat by beat.
// Depends on flc_pkg, flc_if and the core RTL.
`timescale 1ns / 1ps

module full_linear_convolution_i16_core_tb;
	import flc_pkg::*;

	localparam int TAPS = MAX_TAPS_DEF;

	typedef struct {
		logic                       func;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
		bit                         drain; // hold off until every pending output is back
	} conv_beat_t;

	typedef struct {
		logic signed [ACC_W-1:0] value;
		logic                    run_end;
		logic                    final_out;
	} conv_output_t;

	logic clk = 1'b0;
	logic arst_n;

	flc_in_if  in_ch();
	flc_out_if out_ch();

	full_linear_convolution_i16_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #5 clk = ~clk;

	conv_beat_t   pending_beats[$];
	conv_output_t expected_conv[$];
	int           errors = 0;
	bit           calm = 1'b0;
	int           send_gap;
	int           stall;

	// mirror of the core state
	logic signed [SAMPLE_W-1:0] coef[TAPS];
	logic signed [SAMPLE_W-1:0] delay_line[TAPS];
	int                         kernel_len = 0;
	bit                         kernel_done = 1'b0;

	// flip between stretches with and without idle cycles
	always @(posedge clk) begin
		if ($urandom_range(0, 79) == 0)
			calm <= ~calm;
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return SAMPLE_W'(int'($urandom_range(0, 4)) - 2);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic convolve_beat(input conv_beat_t b);
		conv_output_t r;
		int           n_out;
		int           acc;
		if (b.func == FUNC_KERNEL) begin
			if (kernel_done) begin
				kernel_done = 1'b0;
				kernel_len  = 0;
				foreach (delay_line[i]) delay_line[i] = '0;
			end
			if (kernel_len < TAPS) begin
				coef[kernel_len] = b.sample;
				kernel_len++;
			end
			if (b.last)
				kernel_done = 1'b1;
		end else if (kernel_done) begin
			n_out = b.last ? kernel_len : 1;
			for (int t = 0; t < n_out; t++) begin
				for (int i = TAPS - 1; i > 0; i--)
					delay_line[i] = delay_line[i-1];
				delay_line[0] = (t == 0) ? b.sample : '0;
				acc = 0;
				for (int k = 0; k < kernel_len; k++)
					acc += int'(delay_line[k]) * int'(coef[k]);
				r.value     = acc;
				r.run_end   = (t == n_out - 1);
				r.final_out = b.last && (t == n_out - 1);
				expected_conv.push_back(r);
			end
			if (b.last)
				foreach (delay_line[i]) delay_line[i] = '0;
		end
	endtask

	task automatic add_beat(input logic f, input logic signed [SAMPLE_W-1:0] s,
			input logic l, input bit d);
		conv_beat_t b;
		b.func   = f;
		b.sample = s;
		b.last   = l;
		b.drain  = d;
		pending_beats.push_back(b);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid  <= 1'b0;
			in_ch.func   <= FUNC_KERNEL;
			in_ch.sample <= '0;
			in_ch.last   <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				convolve_beat(pending_beats.pop_front());
				send_gap = pick_gap();
			end
			if (in_ch.valid && !in_ch.ready) begin
				// hold the beat until it is taken
			end else if (send_gap > 0) begin
				send_gap--;
				in_ch.valid <= 1'b0;
			end else if (pending_beats.size() != 0 &&
					!(pending_beats[0].drain && expected_conv.size() != 0)) begin
				in_ch.valid  <= 1'b1;
				in_ch.func   <= pending_beats[0].func;
				in_ch.sample <= pending_beats[0].sample;
				in_ch.last   <= pending_beats[0].last;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		conv_output_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_conv.size() == 0) begin
					$error("unexpected result beat, conv_value %0d", out_ch.conv_value);
					errors++;
				end else begin
					want = expected_conv.pop_front();
					if (out_ch.conv_value !== want.value) begin
						$error("conv_value: expected %0d, got %0d", want.value,
							out_ch.conv_value);
						errors++;
					end
					if (out_ch.run_end !== want.run_end) begin
						$error("run_end: expected %0b, got %0b", want.run_end, out_ch.run_end);
						errors++;
					end
					if (out_ch.final_output !== want.final_out) begin
						$error("final_output: expected %0b, got %0b", want.final_out,
							out_ch.final_output);
						errors++;
					end
				end
			end
			if (stall > 0) begin
				stall--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall = pick_gap();
			end
		end
	end

	initial begin
		int roll;
		int klen;
		int slen;
		int runs;
		int rand_items;
		bit broken;
		arst_n = 1'b0;

		// samples before any kernel: dropped
		add_beat(FUNC_SIGNAL, 16'sd1234, 1'b0, 1'b0);
		add_beat(FUNC_SIGNAL, -16'sd1, 1'b1, 1'b0);
		// single-tap kernel, no tail
		add_beat(FUNC_KERNEL, 16'sh8000, 1'b1, 1'b0);
		add_beat(FUNC_SIGNAL, 16'sh8000, 1'b0, 1'b0);
		add_beat(FUNC_SIGNAL, 16'sh7fff, 1'b0, 1'b0);
		add_beat(FUNC_SIGNAL, 16'sd0, 1'b1, 1'b0);
		// same kernel again, after everything has drained
		add_beat(FUNC_SIGNAL, 16'sd1, 1'b1, 1'b1);
		// new kernel of four most-negative taps: sums wrap past 2^31
		for (int i = 0; i < 4; i++)
			add_beat(FUNC_KERNEL, 16'sh8000, i == 3, 1'b0);
		for (int i = 0; i < 4; i++)
			add_beat(FUNC_SIGNAL, 16'sh8000, i == 3, 1'b0);
		// signal cut short by a new kernel, which clears the delay line
		add_beat(FUNC_SIGNAL, 16'sd5, 1'b0, 1'b0);
		add_beat(FUNC_KERNEL, 16'sh7fff, 1'b1, 1'b0);
		add_beat(FUNC_SIGNAL, 16'sd3, 1'b1, 1'b0);

		rand_items = 0;
		while (rand_items < 380) begin
			roll = $urandom_range(0, 99);
			if (roll < 5)
				klen = $urandom_range(TAPS + 1, TAPS + 4); // overlong, last on a dropped tap
			else if (roll < 15)
				klen = $urandom_range(20, TAPS);
			else
				klen = $urandom_range(1, 8);
			for (int k = 0; k < klen; k++) begin
				add_beat(FUNC_KERNEL, rand_sample(), k == klen - 1, 1'b0);
				// stray sample while the kernel is still open: dropped
				if (k == 0 && klen > 1 && $urandom_range(0, 9) == 0)
					add_beat(FUNC_SIGNAL, rand_sample(), 1'($urandom_range(0, 1)), 1'b0);
			end
			rand_items += klen;
			runs = $urandom_range(1, 3);
			for (int r = 0; r < runs; r++) begin
				slen   = $urandom_range(1, 12);
				broken = (r == runs - 1) && ($urandom_range(0, 9) == 0);
				for (int s = 0; s < slen; s++)
					add_beat(FUNC_SIGNAL, rand_sample(), (s == slen - 1) && !broken,
						r > 0 && s == 0 && $urandom_range(0, 7) == 0);
				rand_items += slen;
			end
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do @(posedge clk);
		while (pending_beats.size() != 0 || expected_conv.size() != 0);
		repeat (16) @(posedge clk);

		if (errors == 0)
			$display("full_linear_convolution_i16_core_tb: clean");
		else
			$display("full_linear_convolution_i16_core_tb: errors");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("full_linear_convolution_i16_core_tb: errors");
		$finish;
	end

endmodule
